### src/fdtr_pkg.sv
// shared types and constants of the fan duty thermal ramp unit
package fdtr_pkg;

   localparam int TEMP_W  = 19;                 // signed millidegree fields
   localparam int CDUTY_W = 12;                 // duty configuration registers
   localparam int NUM_W   = TEMP_W + CDUTY_W;   // magnitude of the curve product
   localparam int ALU_W   = NUM_W + 2;          // shared adder width, signed
   localparam int REM_W   = TEMP_W + 1;         // divider partial remainder
   localparam int STEP_W  = $clog2(CDUTY_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CDUTY_W - 1);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = TEMP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TEMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TEMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_TEMP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DUTY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_DUTY  = 3'd4;

   localparam logic signed [TEMP_W-1:0] RST_STOP_TEMP  = 19'sd35000;
   localparam logic signed [TEMP_W-1:0] RST_START_TEMP = 19'sd40000;
   localparam logic signed [TEMP_W-1:0] RST_FULL_TEMP  = 19'sd65000;
   localparam logic [CDUTY_W-1:0]       RST_BASE_DUTY  = 12'd400;
   localparam logic [CDUTY_W-1:0]       RST_FULL_DUTY  = 12'd950;
   localparam int                       RST_DUTY       = 950;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   typedef struct packed {
      logic signed [TEMP_W-1:0] stop_temp;
      logic signed [TEMP_W-1:0] start_temp;
      logic signed [TEMP_W-1:0] full_temp;
      logic [CDUTY_W-1:0]       base_duty;
      logic [CDUTY_W-1:0]       full_duty;
   } cfg_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             inv_b;
      logic             cin;
   } alu_op_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             neg;
      logic             zero;
   } alu_res_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic running;
   } seq_status_type;

endpackage

### src/fdtr_if.sv
// request and response channel interfaces
interface fdtr_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      func;
   logic signed [fdtr_pkg::TEMP_W-1:0]        temp_milli;

   modport source (output valid, output func, output temp_milli, input ready);
   modport sink   (input valid, input func, input temp_milli, output ready);
endinterface

interface fdtr_rsp_if #(parameter int DUTY_BITS = 12);
   logic                 valid;
   logic                 ready;
   logic [DUTY_BITS-1:0] duty;
   logic [DUTY_BITS-1:0] target_duty;
   logic                 running;
   logic                 at_target;

   modport source (output valid, output duty, output target_duty, output running,
                   output at_target, input ready);
   modport sink   (input valid, input duty, input target_duty, input running,
                   input at_target, output ready);
endinterface

### src/fan_duty_thermal_ramp_unit.sv
// top level of the fan duty thermal ramp unit
// ramp tick transaction: compares duty with target, then steps it by one when they differ
// temperature sample: the curve path runs two compares, span setup, a 12-step shift-add
// multiply and a 12-step restoring divide on one adder
// one transaction in flight: the next request waits until the response slot frees up
// synchronous active-high reset restores the config, sets running and both duties to 950
module fan_duty_thermal_ramp_unit #(
   parameter int DUTY_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   fdtr_req_if.sink                         req_ch,
   fdtr_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [fdtr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdtr_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   fdtr_pkg::cfg_type        cfg;
   fdtr_pkg::alu_op_type     alu_op;
   fdtr_pkg::alu_res_type    alu_res;
   fdtr_pkg::seq_status_type status;
   logic [DUTY_BITS-1:0]     seq_duty;
   logic [DUTY_BITS-1:0]     seq_goal;
   logic                     req_fire;
   logic                     rsp_free;

   // response holding register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]     duty_ff, duty_in;
   logic [DUTY_BITS-1:0]     target_ff, target_in;
   logic                     running_ff, running_in;
   logic                     at_target_ff, at_target_in;

   // request taken only while the sequencer sits idle
   assign req_ch.ready = status.idle;
   assign req_fire     = req_ch.valid && status.idle;

   // response slot is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   fdtr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fdtr_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   fdtr_seq #(.DUTY_BITS(DUTY_BITS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_fire (req_fire),
      .req_func (req_ch.func),
      .req_temp (req_ch.temp_milli),
      .rsp_free (rsp_free),
      .alu_op   (alu_op),
      .alu_res  (alu_res),
      .status   (status),
      .duty     (seq_duty),
      .goal     (seq_goal)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      duty_in      = duty_ff;
      target_in    = target_ff;
      running_in   = running_ff;
      at_target_in = at_target_ff;
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;
      // load the finished transaction's state snapshot
      if (status.done) begin
         rsp_valid_in = 1'b1;
         duty_in      = seq_duty;
         target_in    = seq_goal;
         running_in   = status.running;
         at_target_in = (seq_duty == seq_goal);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff      <= duty_in;
      target_ff    <= target_in;
      running_ff   <= running_in;
      at_target_ff <= at_target_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.duty        = duty_ff;
   assign rsp_ch.target_duty = target_ff;
   assign rsp_ch.running     = running_ff;
   assign rsp_ch.at_target   = at_target_ff;

endmodule

### src/fdtr_csr.sv
// configuration register file
module fdtr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fdtr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdtr_pkg::CSR_DAT_W-1:0]    csr_wdata,
   output fdtr_pkg::cfg_type                 cfg
);

   fdtr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fdtr_pkg::CSR_STOP_TEMP:  cfg_in.stop_temp  = csr_wdata;
            fdtr_pkg::CSR_START_TEMP: cfg_in.start_temp = csr_wdata;
            fdtr_pkg::CSR_FULL_TEMP:  cfg_in.full_temp  = csr_wdata;
            fdtr_pkg::CSR_BASE_DUTY:  cfg_in.base_duty  = csr_wdata[fdtr_pkg::CDUTY_W-1:0];
            fdtr_pkg::CSR_FULL_DUTY:  cfg_in.full_duty  = csr_wdata[fdtr_pkg::CDUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_temp  <= fdtr_pkg::RST_STOP_TEMP;
         cfg_ff.start_temp <= fdtr_pkg::RST_START_TEMP;
         cfg_ff.full_temp  <= fdtr_pkg::RST_FULL_TEMP;
         cfg_ff.base_duty  <= fdtr_pkg::RST_BASE_DUTY;
         cfg_ff.full_duty  <= fdtr_pkg::RST_FULL_DUTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/fdtr_alu.sv
// shared adder/subtractor with sign and zero flags
module fdtr_alu (
   input  fdtr_pkg::alu_op_type  op,
   output fdtr_pkg::alu_res_type res
);

   logic [fdtr_pkg::ALU_W-1:0] b_eff;
   logic [fdtr_pkg::ALU_W-1:0] sum;

   assign b_eff = op.inv_b ? ~op.b : op.b;
   assign sum   = op.a + b_eff + fdtr_pkg::ALU_W'(op.cin);

   assign res.sum  = sum;
   assign res.neg  = sum[fdtr_pkg::ALU_W-1];
   assign res.zero = (sum == '0);

endmodule

### src/fdtr_seq.sv
// sequencer: runs compare, multiply and divide steps through the shared adder
module fdtr_seq #(
   parameter int DUTY_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fdtr_pkg::cfg_type                cfg,
   input  logic                             req_fire,
   input  logic                             req_func,
   input  logic signed [fdtr_pkg::TEMP_W-1:0] req_temp,
   input  logic                             rsp_free,
   output fdtr_pkg::alu_op_type             alu_op,
   input  fdtr_pkg::alu_res_type            alu_res,
   output fdtr_pkg::seq_status_type         status,
   output logic [DUTY_BITS-1:0]             duty,
   output logic [DUTY_BITS-1:0]             goal
);

   localparam int AW = fdtr_pkg::ALU_W;
   localparam int CW = fdtr_pkg::CDUTY_W;
   localparam int TW = fdtr_pkg::TEMP_W;
   localparam int RW = fdtr_pkg::REM_W;
   localparam int NW = fdtr_pkg::NUM_W;

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_TICK_CMP  = 14'b00000000000010,
      ST_TICK_STEP = 14'b00000000000100,
      ST_ARM       = 14'b00000000001000,
      ST_CMP_STOP  = 14'b00000000010000,
      ST_CMP_FULL  = 14'b00000000100000,
      ST_DEN       = 14'b00000001000000,
      ST_DD        = 14'b00000010000000,
      ST_NEG       = 14'b00000100000000,
      ST_MUL       = 14'b00001000000000,
      ST_DIV       = 14'b00010000000000,
      ST_FIX       = 14'b00100000000000,
      ST_ADD       = 14'b01000000000000,
      ST_OUT       = 14'b10000000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic                         run_ff, run_in;
   logic [DUTY_BITS-1:0]         out_ff, out_in;
   logic [DUTY_BITS-1:0]         goal_ff, goal_in;
   logic [fdtr_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic signed [TW-1:0]         temp_ff, temp_in;
   logic [TW-1:0]                d1_ff, d1_in;
   logic [TW-1:0]                den_ff, den_in;
   logic [CW-1:0]                mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic                         lt_ff, lt_in;
   logic [AW-1:0]                wk_ff, wk_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [CW-1:0]                quo_ff, quo_in;
   logic [RW-1:0]                rem_shift;

   assign rem_shift = {rem_ff[RW-2:0], quo_ff[CW-1]};

   always_comb begin
      state_in = state_ff;
      run_in   = run_ff;
      out_in   = out_ff;
      goal_in  = goal_ff;
      cnt_in   = cnt_ff;
      temp_in  = temp_ff;
      d1_in    = d1_ff;
      den_in   = den_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      lt_in    = lt_ff;
      wk_in    = wk_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      alu_op   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               temp_in = req_temp;
               if (req_func == fdtr_pkg::FUNC_TICK) state_in = ST_TICK_CMP;
               else if (run_ff)                     state_in = ST_CMP_STOP;
               else                                 state_in = ST_ARM;
            end
         end
         ST_TICK_CMP: begin
            // out - goal, both unsigned
            alu_op = '{a: AW'(out_ff), b: AW'(goal_ff), inv_b: 1'b1, cin: 1'b1};
            lt_in  = alu_res.neg;
            state_in = alu_res.zero ? ST_OUT : ST_TICK_STEP;
         end
         ST_TICK_STEP: begin
            // plus one toward a higher goal, else minus one
            alu_op = '{a: AW'(out_ff), b: AW'(1), inv_b: !lt_ff, cin: !lt_ff};
            out_in = alu_res.sum[DUTY_BITS-1:0];
            state_in = ST_OUT;
         end
         ST_ARM: begin
            alu_op = '{a: AW'(temp_ff), b: AW'(cfg.start_temp), inv_b: 1'b1, cin: 1'b1};
            if (!alu_res.neg) run_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_CMP_STOP: begin
            alu_op = '{a: AW'(temp_ff), b: AW'(cfg.stop_temp), inv_b: 1'b1, cin: 1'b1};
            d1_in  = alu_res.sum[TW-1:0];
            if (alu_res.neg || alu_res.zero) begin
               goal_in  = '0;
               run_in   = 1'b0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_CMP_FULL;
            end
         end
         ST_CMP_FULL: begin
            alu_op = '{a: AW'(temp_ff), b: AW'(cfg.full_temp), inv_b: 1'b1, cin: 1'b1};
            if (!alu_res.neg) begin
               goal_in  = DUTY_BITS'(cfg.full_duty);
               run_in   = (DUTY_BITS'(cfg.full_duty) != '0);
               state_in = ST_OUT;
            end else begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            // stop < t < full here, so the span is positive
            alu_op = '{a: AW'(cfg.full_temp), b: AW'(cfg.stop_temp), inv_b: 1'b1, cin: 1'b1};
            den_in = alu_res.sum[TW-1:0];
            state_in = ST_DD;
         end
         ST_DD: begin
            alu_op = '{a: AW'(cfg.full_duty), b: AW'(cfg.base_duty), inv_b: 1'b1, cin: 1'b1};
            neg_in = alu_res.neg;
            mag_in = alu_res.sum[CW-1:0];
            wk_in  = '0;
            cnt_in = '0;
            state_in = alu_res.neg ? ST_NEG : ST_MUL;
         end
         ST_NEG: begin
            // falling curve: magnitude is base - full
            alu_op = '{a: AW'(cfg.base_duty), b: AW'(cfg.full_duty), inv_b: 1'b1, cin: 1'b1};
            mag_in = alu_res.sum[CW-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // shift-add, multiplier msb first
            alu_op = '{a: {wk_ff[AW-2:0], 1'b0},
                       b: mag_ff[CW-1] ? AW'(d1_ff) : '0,
                       inv_b: 1'b0, cin: 1'b0};
            wk_in  = alu_res.sum;
            mag_in = {mag_ff[CW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == fdtr_pkg::LAST_STEP) begin
               rem_in   = RW'(alu_res.sum[NW-1:CW]);
               quo_in   = alu_res.sum[CW-1:0];
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per step
            alu_op = '{a: AW'(rem_shift), b: AW'(den_ff), inv_b: 1'b1, cin: 1'b1};
            rem_in = alu_res.neg ? rem_shift : alu_res.sum[RW-1:0];
            quo_in = {quo_ff[CW-2:0], !alu_res.neg};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == fdtr_pkg::LAST_STEP) state_in = ST_FIX;
         end
         ST_FIX: begin
            // negative product: floor gives -q-1 with remainder, -q without
            alu_op = '{a: '0, b: AW'(quo_ff), inv_b: neg_ff,
                       cin: neg_ff && (rem_ff == '0)};
            wk_in  = alu_res.sum;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            alu_op = '{a: wk_ff, b: AW'(cfg.base_duty), inv_b: 1'b0, cin: 1'b0};
            goal_in  = alu_res.neg ? '0 : alu_res.sum[DUTY_BITS-1:0];
            run_in   = !alu_res.neg && (alu_res.sum[DUTY_BITS-1:0] != '0);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         run_ff   <= 1'b1;
         out_ff   <= DUTY_BITS'(fdtr_pkg::RST_DUTY);
         goal_ff  <= DUTY_BITS'(fdtr_pkg::RST_DUTY);
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         out_ff   <= out_in;
         goal_ff  <= goal_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      d1_ff   <= d1_in;
      den_ff  <= den_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      lt_ff   <= lt_in;
      wk_ff   <= wk_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign status.idle    = (state_ff == ST_IDLE);
   assign status.done    = (state_ff == ST_OUT) && rsp_free;
   assign status.running = run_ff;
   assign duty           = out_ff;
   assign goal           = goal_ff;

endmodule

### src/fdtr_checker.sv
// port-level checker for the fan duty thermal ramp unit and its bind
module fdtr_checker #(
   parameter int DUTY_BITS = 12
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DUTY_BITS-1:0] duty,
   input logic [DUTY_BITS-1:0] target_duty,
   input logic                 running,
   input logic                 at_target
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty) && $stable(target_duty))
      else $error("response changed while stalled");

   // one transaction at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_at_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> at_target == (duty == target_duty))
      else $error("at_target disagrees with duties");

   // a stopped fan always heads toward zero duty
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !running |-> target_duty == '0)
      else $error("stopped with nonzero target");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fan_duty_thermal_ramp_unit fdtr_checker #(.DUTY_BITS(DUTY_BITS)) u_fdtr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .duty        (rsp_ch.duty),
   .target_duty (rsp_ch.target_duty),
   .running     (rsp_ch.running),
   .at_target   (rsp_ch.at_target)
);

### verif/fan_duty_thermal_ramp_unit_test.sv
// self-checking testbench for the fan duty thermal ramp unit: directed probes, then random phases
module fan_duty_thermal_ramp_unit_test;

   localparam int DUTY_BITS     = 12;
   localparam int PHASE_ITEMS   = 120;   // random transactions per register setting
   localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register write
   localparam int TAIL_CYCLES   = 40;    // covers the slowest sample transaction
   localparam int STALL_LIMIT   = 3000;  // cycles without any transaction before giving up

   // register settings used by the directed table and the phase plan
   localparam int SET_RESET     = 0;  // power-on values
   localparam int SET_SMALL     = 1;  // tiny duties so the ramp settles often
   localparam int SET_WIDE      = 2;  // whole temperature range, whole duty range
   localparam int SET_FALLING   = 3;  // full duty below base duty, narrow span
   localparam int SET_RAW       = 4;  // register words at the 19-bit extremes
   localparam int SET_ZERO_BASE = 5;  // zero base duty, curve can round down to zero
   localparam int SET_EMPTY     = 6;  // full threshold below stop threshold
   localparam int SET_SHUFFLED  = 7;  // drawn at random

   typedef logic [fdtr_pkg::CSR_DAT_W-1:0] csr_word_type;

   typedef struct packed {
      csr_word_type stop_w;
      csr_word_type start_w;
      csr_word_type full_w;
      csr_word_type base_w;
      csr_word_type fullduty_w;
   } fan_setting_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic [DUTY_BITS-1:0] target;
      logic                 running;
      logic                 at_target;
   } duty_report_type;

   typedef struct {
      int   setting;
      logic op;
      int   temp;
      bit   pinned;
      int   want_duty;
      int   want_target;
      bit   want_run;
      bit   want_at;
   } probe_type;

   // directed probes; only the rows right after reset carry a typed expectation
   probe_type probes [25] = '{
      '{SET_RESET,     fdtr_pkg::FUNC_TICK,   0,       1, 950, 950, 1, 1},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 150000,  1, 950, 950, 1, 1},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 50000,   0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_TICK,   0,       0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 35000,   0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 39999,   0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 40000,   0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 35001,   0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, -262144, 0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 262143,  0, 0, 0, 0, 0},
      '{SET_RESET,     fdtr_pkg::FUNC_SAMPLE, 262143,  0, 0, 0, 0, 0},
      '{SET_FALLING,   fdtr_pkg::FUNC_SAMPLE, 50,      0, 0, 0, 0, 0},
      '{SET_FALLING,   fdtr_pkg::FUNC_SAMPLE, 33,      0, 0, 0, 0, 0},
      '{SET_FALLING,   fdtr_pkg::FUNC_SAMPLE, 100,     0, 0, 0, 0, 0},
      '{SET_FALLING,   fdtr_pkg::FUNC_SAMPLE, 0,       0, 0, 0, 0, 0},
      '{SET_EMPTY,     fdtr_pkg::FUNC_SAMPLE, -40000,  0, 0, 0, 0, 0},
      '{SET_EMPTY,     fdtr_pkg::FUNC_SAMPLE, 45000,   0, 0, 0, 0, 0},
      '{SET_EMPTY,     fdtr_pkg::FUNC_SAMPLE, -40000,  0, 0, 0, 0, 0},
      '{SET_EMPTY,     fdtr_pkg::FUNC_SAMPLE, 50001,   0, 0, 0, 0, 0},
      '{SET_EMPTY,     fdtr_pkg::FUNC_TICK,   0,       0, 0, 0, 0, 0},
      '{SET_ZERO_BASE, fdtr_pkg::FUNC_SAMPLE, 1,       0, 0, 0, 0, 0},
      '{SET_ZERO_BASE, fdtr_pkg::FUNC_SAMPLE, 10,      0, 0, 0, 0, 0},
      '{SET_ZERO_BASE, fdtr_pkg::FUNC_SAMPLE, 99999,   0, 0, 0, 0, 0},
      '{SET_RAW,       fdtr_pkg::FUNC_SAMPLE, 262142,  0, 0, 0, 0, 0},
      '{SET_RAW,       fdtr_pkg::FUNC_SAMPLE, 262143,  0, 0, 0, 0, 0}
   };

   // random phases: idle pattern follows the phase index
   int phase_plan [9] = '{SET_SMALL, SET_WIDE, SET_RESET, SET_FALLING, SET_RAW,
                          SET_ZERO_BASE, SET_EMPTY, SET_SHUFFLED, SET_SHUFFLED};

   logic clock;
   logic reset = 1'b1;

   // channel drivers, known from time zero
   logic                           req_on    = 1'b0;
   logic                           req_func  = fdtr_pkg::FUNC_SAMPLE;
   logic [fdtr_pkg::TEMP_W-1:0]    req_temp  = '0;
   logic                           rsp_take  = 1'b0;
   logic                           csr_we    = 1'b0;
   logic [fdtr_pkg::CSR_IDX_W-1:0] csr_index = fdtr_pkg::CSR_STOP_TEMP;
   csr_word_type                   csr_wdata = '0;

   fdtr_req_if                          req_bus ();
   fdtr_rsp_if #(.DUTY_BITS(DUTY_BITS)) rsp_bus ();

   assign req_bus.valid      = req_on;
   assign req_bus.func       = req_func;
   assign req_bus.temp_milli = req_temp;
   assign rsp_bus.ready      = rsp_take;

   fan_duty_thermal_ramp_unit #(.DUTY_BITS(DUTY_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the registers
   logic signed [fdtr_pkg::TEMP_W-1:0] cur_stop;
   logic signed [fdtr_pkg::TEMP_W-1:0] cur_start;
   logic signed [fdtr_pkg::TEMP_W-1:0] cur_full;
   logic [fdtr_pkg::CDUTY_W-1:0]       cur_base;
   logic [fdtr_pkg::CDUTY_W-1:0]       cur_fullduty;

   // shadow copy of the controller state
   logic                 fan_on;
   logic [DUTY_BITS-1:0] drive_duty;
   logic [DUTY_BITS-1:0] goal;

   duty_report_type owed_reports [$];   // predicted responses, oldest first
   logic            hold_pin = 1'b0;    // next accepted transaction uses pinned_report
   duty_report_type pinned_report;

   int req_idle_pct = 29;
   int rsp_idle_pct = 82;
   int req_calm     = 0;             // transactions left in a no-gap stretch
   int rsp_calm     = 0;             // cycles left in an always-ready stretch

   int mismatches      = 0;
   int stall_cycles    = 0;
   int samples_seen    = 0;
   int ticks_seen      = 0;
   int at_target_hits  = 0;
   int stopped_reports = 0;
   int settings_loaded = 0;

   fan_setting_type presets [7];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // predictor
   // --------------------------------------------------------------------

   function automatic fan_setting_type mk_setting(int stop, int start, int full, int base,
                                                  int fullduty);
      fan_setting_type s;
      s.stop_w     = 19'(stop);
      s.start_w    = 19'(start);
      s.full_w     = 19'(full);
      s.base_w     = 19'(base);
      s.fullduty_w = 19'(fullduty);
      return s;
   endfunction

   function automatic void shadow_register(logic [fdtr_pkg::CSR_IDX_W-1:0] idx,
                                           csr_word_type word);
      case (idx)
         fdtr_pkg::CSR_STOP_TEMP:  cur_stop     = word;
         fdtr_pkg::CSR_START_TEMP: cur_start    = word;
         fdtr_pkg::CSR_FULL_TEMP:  cur_full     = word;
         fdtr_pkg::CSR_BASE_DUTY:  cur_base     = word[fdtr_pkg::CDUTY_W-1:0];
         fdtr_pkg::CSR_FULL_DUTY:  cur_fullduty = word[fdtr_pkg::CDUTY_W-1:0];
         default: ;
      endcase
   endfunction

   // linear fan curve between the stop and full thresholds, floor toward minus infinity
   function automatic logic [DUTY_BITS-1:0] curve_duty(logic signed [fdtr_pkg::TEMP_W-1:0] t);
      longint num;
      longint den;
      longint q;
      num = (longint'(t) - longint'(cur_stop)) *
            (longint'(cur_fullduty) - longint'(cur_base));
      den = longint'(cur_full) - longint'(cur_stop);
      if (den <= 0)
         return cur_base;
      q = num / den;
      if (num < 0 && (num % den) != 0)
         q = q - 1;
      q = q + longint'(cur_base);
      if (q < 0)
         q = 0;
      return q[DUTY_BITS-1:0];
   endfunction

   // one transaction through the controller: hysteresis, target, ramp step
   function automatic duty_report_type advance_fan(logic op,
                                                   logic signed [fdtr_pkg::TEMP_W-1:0] t);
      duty_report_type r;
      logic [DUTY_BITS-1:0] g;
      if (op == fdtr_pkg::FUNC_SAMPLE) begin
         if (fan_on) begin
            if (t <= cur_stop)
               g = '0;
            else if (t >= cur_full)
               g = cur_fullduty;
            else
               g = curve_duty(t);
            goal   = g;
            fan_on = (g != 0);
         end else if (t >= cur_start) begin
            // re-arm only, target waits for the next sample
            fan_on = 1'b1;
         end
      end else begin
         if (drive_duty < goal)
            drive_duty = drive_duty + 1'b1;
         else if (drive_duty > goal)
            drive_duty = drive_duty - 1'b1;
      end
      r.duty      = drive_duty;
      r.target    = goal;
      r.running   = fan_on;
      r.at_target = (drive_duty == goal);
      return r;
   endfunction

   function automatic void check_field(string name, logic [DUTY_BITS-1:0] want,
                                       logic [DUTY_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // --------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------

   // temperatures around the thresholds, inside the curve, in range, or any 19-bit word
   function automatic logic signed [fdtr_pkg::TEMP_W-1:0] pick_temp();
      int span;
      span = int'(cur_full) - int'(cur_stop);
      case ($urandom_range(11, 0))
         0:       return cur_stop;
         1:       return cur_stop + 1'b1;
         2:       return cur_stop - 1'b1;
         3:       return cur_start;
         4:       return cur_start - 1'b1;
         5:       return cur_full;
         6:       return cur_full - 1'b1;
         7:       return cur_full + 1'b1;
         8, 9: begin
            if (span > 1)
               return 19'(int'(cur_stop) + int'($urandom_range(span - 1, 1)));
            return 19'(int'($urandom_range(190000, 0)) - 40000);
         end
         10:      return 19'(int'($urandom_range(190000, 0)) - 40000);
         default: return 19'($urandom);
      endcase
   endfunction

   function automatic fan_setting_type random_setting();
      int lo;
      int a;
      int b;
      int c;
      int bd;
      int fd;
      if ($urandom_range(3, 0) != 0) begin
         // ordered thresholds, the usual shape
         lo = int'($urandom_range(100000, 0)) - 40000;
         a  = lo;
         b  = lo + int'($urandom_range(8000, 0));
         c  = lo + int'($urandom_range(50000, 1));
      end else begin
         a = int'($urandom);
         b = int'($urandom);
         c = int'($urandom);
      end
      if ($urandom_range(1, 0) != 0) begin
         bd = int'($urandom_range(20, 0));
         fd = int'($urandom_range(24, 1));
      end else begin
         bd = int'($urandom_range(4095, 0));
         fd = int'($urandom_range(4095, 1));
      end
      return mk_setting(a, b, c, bd, fd);
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic write_csr(logic [fdtr_pkg::CSR_IDX_W-1:0] idx, csr_word_type word);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      shadow_register(idx, word);
      @(negedge clock);
   endtask

   task automatic load_setting(fan_setting_type s);
      write_csr(fdtr_pkg::CSR_STOP_TEMP,  s.stop_w);
      write_csr(fdtr_pkg::CSR_START_TEMP, s.start_w);
      write_csr(fdtr_pkg::CSR_FULL_TEMP,  s.full_w);
      write_csr(fdtr_pkg::CSR_BASE_DUTY,  s.base_w);
      write_csr(fdtr_pkg::CSR_FULL_DUTY,  s.fullduty_w);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // offer one request transaction, with an optional random gap in front
   task automatic send_item(logic op, logic [fdtr_pkg::TEMP_W-1:0] temp);
      if (req_calm != 0)
         req_calm--;
      else if ($urandom_range(31, 0) == 0)
         req_calm = $urandom_range(30, 5);
      while (req_calm == 0 && $urandom_range(99, 0) < req_idle_pct) begin
         req_on <= 1'b0;
         @(negedge clock);
      end
      // valid stays high between back-to-back transactions
      req_on   <= 1'b1;
      req_func <= op;
      req_temp <= temp;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
      hold_pin = 1'b0;
   endtask

   // hold off the sender until every predicted response has come back
   task automatic drain_all();
      req_on <= 1'b0;
      while (owed_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // --------------------------------------------------------------------
   // response side: random back-pressure with always-ready stretches
   // --------------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_calm != 0) begin
         rsp_calm = rsp_calm - 1;
         rsp_take <= 1'b1;
      end else begin
         if ($urandom_range(63, 0) == 0)
            rsp_calm = $urandom_range(40, 8);
         rsp_take <= ($urandom_range(99, 0) >= rsp_idle_pct);
      end
   end

   // --------------------------------------------------------------------
   // monitor: check responses, predict accepted requests, watchdog
   // --------------------------------------------------------------------

   always @(posedge clock) begin
      duty_report_type want;
      logic            moved;
      if (!reset) begin
         moved = 1'b0;

         // response transaction against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (owed_reports.size() == 0) begin
               $error("response with no request outstanding: duty %0d target %0d",
                      rsp_bus.duty, rsp_bus.target_duty);
               mismatches++;
            end else begin
               want = owed_reports.pop_front();
               check_field("duty", want.duty, rsp_bus.duty);
               check_field("target_duty", want.target, rsp_bus.target_duty);
               check_field("running", DUTY_BITS'(want.running), DUTY_BITS'(rsp_bus.running));
               check_field("at_target", DUTY_BITS'(want.at_target),
                           DUTY_BITS'(rsp_bus.at_target));
            end
            if (rsp_bus.at_target === 1'b1)
               at_target_hits++;
            if (rsp_bus.running === 1'b0)
               stopped_reports++;
         end

         // request transaction: advance the shadow state
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            want  = advance_fan(req_bus.func, req_bus.temp_milli);
            if (hold_pin)
               want = pinned_report;
            owed_reports.push_back(want);
            if (req_bus.func == fdtr_pkg::FUNC_SAMPLE)
               samples_seen++;
            else
               ticks_seen++;
         end

         if (moved)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                   STALL_LIMIT, owed_reports.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------

   initial begin
      int cur_set;
      int p;
      int k;
      int sent;
      int ticks;

      presets[SET_RESET]     = mk_setting(35000, 40000, 65000, 400, 950);
      presets[SET_SMALL]     = mk_setting(20000, 25000, 30000, 2, 12);
      presets[SET_WIDE]      = mk_setting(-40000, -40000, 150000, 0, 4095);
      presets[SET_FALLING]   = mk_setting(0, 150000, 100, 4095, 1);
      // upper bits of the duty words are dropped: base reads 4095, full duty reads 0
      presets[SET_RAW]       = mk_setting(-262144, 262143, 262143, 'h7FFFF, 'h7F000);
      presets[SET_ZERO_BASE] = mk_setting(0, 10, 100000, 0, 3);
      presets[SET_EMPTY]     = mk_setting(50000, -40000, 40000, 7, 9);

      // shadow state as it comes out of reset
      cur_stop     = fdtr_pkg::RST_STOP_TEMP;
      cur_start    = fdtr_pkg::RST_START_TEMP;
      cur_full     = fdtr_pkg::RST_FULL_TEMP;
      cur_base     = fdtr_pkg::RST_BASE_DUTY;
      cur_fullduty = fdtr_pkg::RST_FULL_DUTY;
      fan_on       = 1'b1;
      drive_duty   = DUTY_BITS'(fdtr_pkg::RST_DUTY);
      goal         = DUTY_BITS'(fdtr_pkg::RST_DUTY);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed probes, sender sparse and receiver mostly stalled
      cur_set = SET_RESET;
      foreach (probes[i]) begin
         if (probes[i].setting != cur_set) begin
            drain_all();
            load_setting(presets[probes[i].setting]);
            cur_set = probes[i].setting;
         end
         if (probes[i].pinned) begin
            pinned_report.duty      = DUTY_BITS'(probes[i].want_duty);
            pinned_report.target    = DUTY_BITS'(probes[i].want_target);
            pinned_report.running   = probes[i].want_run;
            pinned_report.at_target = probes[i].want_at;
            hold_pin = 1'b1;
         end
         send_item(probes[i].op, 19'(probes[i].temp));
      end

      // random phases: a sample followed by a run of ramp ticks, with some noise
      for (p = 0; p < 9; p++) begin
         drain_all();
         if (phase_plan[p] == SET_SHUFFLED)
            load_setting(random_setting());
         else
            load_setting(presets[phase_plan[p]]);

         if (p < 3) begin
            req_idle_pct = 29;
            rsp_idle_pct = 82;
         end else if (p < 6) begin
            req_idle_pct = 82;
            rsp_idle_pct = 29;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(9, 0) == 0) begin
               send_item(1'($urandom), 19'($urandom));
               sent++;
            end else begin
               send_item(fdtr_pkg::FUNC_SAMPLE, pick_temp());
               // long tick runs let the duty catch up with its target
               ticks = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 0);
               for (k = 0; k < ticks; k++)
                  send_item(fdtr_pkg::FUNC_TICK, 19'($urandom));
               sent += ticks + 1;
            end
            if ($urandom_range(59, 0) == 0)
               drain_all();
         end
      end

      req_on <= 1'b0;
      while (owed_reports.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d temperature samples and %0d ramp ticks under %0d register settings",
               samples_seen, ticks_seen, settings_loaded);
      $display("%0d responses had the duty at its target, %0d had the fan stopped",
               at_target_hits, stopped_reports);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
src/fdtr_pkg.sv
src/fdtr_if.sv
src/fdtr_csr.sv
src/fdtr_alu.sv
src/fdtr_seq.sv
src/fan_duty_thermal_ramp_unit.sv
src/fdtr_checker.sv
verif/fan_duty_thermal_ramp_unit_test.sv
